FILE: rtl/avt_pkg.sv
// shared types and constants for the affine vertex transform
// no dependencies; used by avt_row and affine_vertex_transform
package avt_pkg;

  // default widths of one matrix entry and one coordinate
  localparam int COEFF_WIDTH_DEF = 16;
  localparam int COORD_WIDTH_DEF = 32;

  // fixed point layout: Q4.12 entries, Q16.16 coordinates and results
  localparam int COEFF_FRAC = 12;
  localparam int COORD_FRAC = 16;
  localparam int OUT_WIDTH  = 32;

  // matrix rows
  localparam int ROW_COUNT = 4;
  localparam int ROW_WIDTH = 64;

  // identity matrix after reset
  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  // register indexes on the write port
  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_ROW3 = 2'd3
  } reg_index_t;

  // operation codes; the unused code behaves as a point
  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_VECTOR = 2'd1,
    OP_HOMOG  = 2'd2
  } op_t;

  // one saturated row result
  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        sat;
  } row_result_t;

endpackage

FILE: rtl/avt_row.sv
// one matrix row dot product: multiply, sum, round and saturate stages
// depends on avt_pkg
module avt_row #(
  parameter int COEFF_WIDTH = avt_pkg::COEFF_WIDTH_DEF,
  parameter int COORD_WIDTH = avt_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           translate,
  input  logic signed [COEFF_WIDTH-1:0]  coeff_a,
  input  logic signed [COEFF_WIDTH-1:0]  coeff_b,
  input  logic signed [COEFF_WIDTH-1:0]  coeff_c,
  input  logic signed [COEFF_WIDTH-1:0]  coeff_d,
  input  logic signed [COORD_WIDTH-1:0]  coord_x,
  input  logic signed [COORD_WIDTH-1:0]  coord_y,
  input  logic signed [COORD_WIDTH-1:0]  coord_z,
  output avt_pkg::row_result_t           result
);

  localparam int P  = COEFF_WIDTH + COORD_WIDTH;
  localparam int S  = P + 2;
  localparam int QS = S - avt_pkg::COEFF_FRAC;
  localparam int QW = (QS > avt_pkg::OUT_WIDTH) ? QS : avt_pkg::OUT_WIDTH + 1;

  localparam logic signed [S-1:0] ROUND_HALF = S'(1) <<< (avt_pkg::COEFF_FRAC - 1);
  localparam logic signed [QW-1:0] SAT_MAX =
    {{(QW - avt_pkg::OUT_WIDTH + 1){1'b0}}, {(avt_pkg::OUT_WIDTH - 1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_MIN = ~SAT_MAX;

  // product stage
  logic signed [P-1:0] prod_a;
  logic signed [P-1:0] prod_b;
  logic signed [P-1:0] prod_c;
  logic signed [S-1:0] offset;

  // sum stage
  logic signed [S-1:0] sum;

  // round and saturate
  logic signed [QS-1:0] quot;
  logic signed [QW-1:0] quot_ext;
  avt_pkg::row_result_t result_next;

  always_ff @(posedge clk) begin
    prod_a <= coeff_a * coord_x;
    prod_b <= coeff_b * coord_y;
    prod_c <= coeff_c * coord_z;
    if (translate) begin
      offset <= S'(coeff_d) <<< avt_pkg::COORD_FRAC;
    end else begin
      offset <= '0;
    end
  end

  always_ff @(posedge clk) begin
    sum <= S'(prod_a) + S'(prod_b) + S'(prod_c) + offset + ROUND_HALF;
  end

  always_comb begin
    quot     = sum[S-1:avt_pkg::COEFF_FRAC];
    quot_ext = QW'(quot);
    if (quot_ext > SAT_MAX) begin
      result_next.value = SAT_MAX[avt_pkg::OUT_WIDTH-1:0];
      result_next.sat   = 1'b1;
    end else if (quot_ext < SAT_MIN) begin
      result_next.value = SAT_MIN[avt_pkg::OUT_WIDTH-1:0];
      result_next.sat   = 1'b1;
    end else begin
      result_next.value = quot_ext[avt_pkg::OUT_WIDTH-1:0];
      result_next.sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

FILE: rtl/affine_vertex_transform.sv
// top level of the affine vertex transform: matrix registers, valid pipeline, output stage
// depends on avt_pkg and avt_row
//
// Takes one vertex transaction per clock (start high while busy is low; busy is only
// high during reset) and returns its result as a one-cycle done strobe with out_x,
// out_y, out_z, out_w and overflow. The rate is one transaction every cycle, set by
// the pipeline: input register, a bank of twelve signed multipliers (one per entry
// of the first three matrix columns), the row adders, round and saturate, then the
// output register. Results cannot be held off, so none are ever queued. The four
// matrix rows are loaded through wr_en / wr_index / wr_data and reset to the
// identity; they should only be written while no transaction is in flight.
module affine_vertex_transform #(
  parameter int COEFF_WIDTH = avt_pkg::COEFF_WIDTH_DEF,
  parameter int COORD_WIDTH = avt_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // command side
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            operation,
  input  logic signed [COORD_WIDTH-1:0]         coord_x,
  input  logic signed [COORD_WIDTH-1:0]         coord_y,
  input  logic signed [COORD_WIDTH-1:0]         coord_z,
  // result side
  output logic                                  done,
  output logic signed [avt_pkg::OUT_WIDTH-1:0]  out_x,
  output logic signed [avt_pkg::OUT_WIDTH-1:0]  out_y,
  output logic signed [avt_pkg::OUT_WIDTH-1:0]  out_z,
  output logic signed [avt_pkg::OUT_WIDTH-1:0]  out_w,
  output logic                                  overflow,
  // register write port
  input  logic                                  wr_en,
  input  logic [1:0]                            wr_index,
  input  logic [avt_pkg::ROW_WIDTH-1:0]         wr_data
);

  localparam int RW = avt_pkg::ROW_WIDTH;

  // matrix rows, packed so entries can be sliced at fixed offsets
  logic [avt_pkg::ROW_COUNT-1:0][RW-1:0] matrix;

  // entries per row and column, sliced from the row bit fields
  logic signed [COEFF_WIDTH-1:0] coeff [avt_pkg::ROW_COUNT][4];

  // stage 1: registered input transaction
  logic                          valid1;
  logic [1:0]                    op1;
  logic signed [COORD_WIDTH-1:0] x1;
  logic signed [COORD_WIDTH-1:0] y1;
  logic signed [COORD_WIDTH-1:0] z1;

  // operation and valid travel alongside the row pipelines
  logic       valid2, valid3, valid4;
  logic [1:0] op2, op3, op4;

  logic translate1;
  logic accept;

  avt_pkg::row_result_t row_res [avt_pkg::ROW_COUNT];

  // no stall ever reaches the input; only reset holds it off
  assign busy   = rst;
  assign accept = start && !busy;

  // register writes, every index maps to a row
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= avt_pkg::ROW0_RESET;
      matrix[1] <= avt_pkg::ROW1_RESET;
      matrix[2] <= avt_pkg::ROW2_RESET;
      matrix[3] <= avt_pkg::ROW3_RESET;
    end else if (wr_en) begin
      case (wr_index)
        avt_pkg::REG_ROW0: matrix[0] <= wr_data;
        avt_pkg::REG_ROW1: matrix[1] <= wr_data;
        avt_pkg::REG_ROW2: matrix[2] <= wr_data;
        avt_pkg::REG_ROW3: matrix[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // entry slicing: a field that runs past bit 63 is zero filled, one beyond it is zero
  for (genvar r = 0; r < avt_pkg::ROW_COUNT; r++) begin : g_row_slice
    for (genvar c = 0; c < 4; c++) begin : g_col_slice
      localparam int SH = c * COEFF_WIDTH;
      if (SH + COEFF_WIDTH <= RW) begin : g_full
        assign coeff[r][c] = matrix[r][SH +: COEFF_WIDTH];
      end else if (SH < RW) begin : g_part
        assign coeff[r][c] = COEFF_WIDTH'(matrix[r][RW-1:SH]);
      end else begin : g_none
        assign coeff[r][c] = '0;
      end
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
      valid3 <= valid2;
      valid4 <= valid3;
      done   <= valid4;
    end
  end

  // payload pipeline, no reset needed
  always_ff @(posedge clk) begin
    op1 <= operation;
    x1  <= coord_x;
    y1  <= coord_y;
    z1  <= coord_z;
    op2 <= op1;
    op3 <= op2;
    op4 <= op3;
  end

  // translation column is dropped only for a direction vector
  assign translate1 = (op1 != avt_pkg::OP_VECTOR);

  for (genvar r = 0; r < avt_pkg::ROW_COUNT; r++) begin : g_rows
    // the w row always takes its translation entry
    logic row_translate;
    if (r == avt_pkg::ROW_COUNT - 1) begin : g_w
      assign row_translate = 1'b1;
    end else begin : g_xyz
      assign row_translate = translate1;
    end

    avt_row #(
      .COEFF_WIDTH (COEFF_WIDTH),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_row (
      .clk       (clk),
      .translate (row_translate),
      .coeff_a   (coeff[r][0]),
      .coeff_b   (coeff[r][1]),
      .coeff_c   (coeff[r][2]),
      .coeff_d   (coeff[r][3]),
      .coord_x   (x1),
      .coord_y   (y1),
      .coord_z   (z1),
      .result    (row_res[r])
    );
  end

  // output stage: w only in homogeneous mode, overflow over the produced rows
  always_ff @(posedge clk) begin
    out_x <= row_res[0].value;
    out_y <= row_res[1].value;
    out_z <= row_res[2].value;
    if (op4 == avt_pkg::OP_HOMOG) begin
      out_w    <= row_res[3].value;
      overflow <= row_res[0].sat | row_res[1].sat | row_res[2].sat | row_res[3].sat;
    end else begin
      out_w    <= '0;
      overflow <= row_res[0].sat | row_res[1].sat | row_res[2].sat;
    end
  end

  // fixed latency from accepted transaction to result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("result strobe missing five cycles after a transaction");

  // no stray result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !done)
    else $error("result strobe right after reset");

  // a non-zero w only comes from a homogeneous transaction
  a_w_mode: assert property (@(posedge clk) disable iff (rst)
    (done && out_w != '0) |-> $past(op4 == avt_pkg::OP_HOMOG))
    else $error("w produced outside homogeneous mode");

  // overflow implies at least one component sits at a saturation bound
  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |->
      (out_x == {1'b0, {(avt_pkg::OUT_WIDTH-1){1'b1}}} ||
       out_x == {1'b1, {(avt_pkg::OUT_WIDTH-1){1'b0}}} ||
       out_y == {1'b0, {(avt_pkg::OUT_WIDTH-1){1'b1}}} ||
       out_y == {1'b1, {(avt_pkg::OUT_WIDTH-1){1'b0}}} ||
       out_z == {1'b0, {(avt_pkg::OUT_WIDTH-1){1'b1}}} ||
       out_z == {1'b1, {(avt_pkg::OUT_WIDTH-1){1'b0}}} ||
       out_w == {1'b0, {(avt_pkg::OUT_WIDTH-1){1'b1}}} ||
       out_w == {1'b1, {(avt_pkg::OUT_WIDTH-1){1'b0}}}))
    else $error("overflow flagged without a saturated component");

endmodule
